// File: design/bcpc_pkg.sv
// Shared types, constants and lookup tables for the BLDC commutation and
// position control unit. Depends on nothing; every design file imports it.

package bcpc_pkg;

   // Field and datapath widths
   localparam int HALL_W  = 3;
   localparam int PHASE_W = 6;
   localparam int DUTY_W  = 10;
   localparam int POS_W   = 32;
   localparam int ACC_W   = 46;   // holds every exact controller sum

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Controller constants
   localparam logic [DUTY_W-1:0] DUTY_MAX       = 10'd1000;
   localparam logic signed [4:0] TICKS_PER_SEC  = 5'sd10;
   localparam logic signed [5:0] PHASE_LEAD     = 6'sd2;
   localparam logic signed [5:0] STATES_PER_REV = 6'sd6;

   // Reset values of the configuration registers
   localparam logic [7:0] PROP_GAIN_RESET  = 8'd25;
   localparam logic [7:0] DERIV_GAIN_RESET = 8'd15;

   // Kind of input word, carried on tuser
   typedef enum logic {
      OP_HALL_EDGE = 1'b0,
      OP_CTRL_TICK = 1'b1
   } op_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROTOR_ORIGIN    = 3'd0,
      CSR_PROP_GAIN       = 3'd1,
      CSR_DERIV_GAIN      = 3'd2,
      CSR_MAX_SPEED       = 3'd3,
      CSR_TARGET_POSITION = 3'd4
   } csr_index_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [2:0]       rotor_origin;
      logic [7:0]       prop_gain;
      logic [7:0]       deriv_gain;
      logic [15:0]      max_speed;
      logic [POS_W-1:0] target_position;
   } cfg_type;

   // Outcome of a hall edge
   typedef struct packed {
      logic [HALL_W-1:0]  rotor_state;
      logic [PHASE_W-1:0] phase_enables;
      logic [DUTY_W-1:0]  duty;
      logic [POS_W-1:0]   position;
   } hall_result_type;

   // Outcome of a control tick
   typedef struct packed {
      logic [POS_W-1:0] drive_value;
      logic [POS_W-1:0] speed;
   } tick_result_type;

   // Result word, first field in the highest bits
   typedef struct packed {
      logic [POS_W-1:0]   speed;
      logic [POS_W-1:0]   drive_value;
      logic [POS_W-1:0]   position;
      logic [DUTY_W-1:0]  duty;
      logic [PHASE_W-1:0] phase_enables;
   } rsp_word_type;

   // Drive state to switch pattern; states six and seven switch everything off
   function automatic logic [PHASE_W-1:0] phase_lookup(input logic [2:0] drive_state);
      logic [PHASE_W-1:0] pattern;
      case (drive_state)
         3'd0:    pattern = 6'h12;
         3'd1:    pattern = 6'h18;
         3'd2:    pattern = 6'h09;
         3'd3:    pattern = 6'h21;
         3'd4:    pattern = 6'h24;
         3'd5:    pattern = 6'h06;
         default: pattern = 6'h00;
      endcase
      return pattern;
   endfunction

   // Sensor code to rotor state; the two impossible codes give state seven
   function automatic logic [HALL_W-1:0] hall_lookup(input logic [HALL_W-1:0] hall);
      logic [HALL_W-1:0] rs;
      case (hall)
         3'd0:    rs = 3'd7;
         3'd1:    rs = 3'd5;
         3'd2:    rs = 3'd3;
         3'd3:    rs = 3'd4;
         3'd4:    rs = 3'd1;
         3'd5:    rs = 3'd0;
         3'd6:    rs = 3'd2;
         default: rs = 3'd7;
      endcase
      return rs;
   endfunction

endpackage

// File: design/bcpc_commutation.sv
// Hall edge datapath: rotor state decode, drive state and phase pattern,
// duty from the last drive value, and position update. Uses bcpc_pkg.

module bcpc_commutation
   import bcpc_pkg::*;
(
   input  logic [HALL_W-1:0] hall_state,
   input  logic [2:0]        rotor_origin,
   input  logic [POS_W-1:0]  control_value,
   input  logic [HALL_W-1:0] last_rotor_state,
   input  logic [POS_W-1:0]  rotor_position,
   output hall_result_type   result
);

   logic [HALL_W-1:0] rotor_state;
   logic              drive_negative;
   logic [POS_W:0]    magnitude;
   logic [DUTY_W-1:0] duty_limited;
   logic signed [5:0] state_sum;
   logic signed [5:0] state_rem;
   logic signed [3:0] state_diff;
   logic signed [3:0] pos_step;

   // Drive state: (rotor - origin + lead + 6) with a truncating remainder by six
   always_comb begin
      rotor_state    = hall_lookup(hall_state);
      drive_negative = control_value[POS_W-1];
      state_sum      = $signed({3'b000, rotor_state}) - $signed({3'b000, rotor_origin})
                       + (drive_negative ? -PHASE_LEAD : PHASE_LEAD) + STATES_PER_REV;
      // A negative sum never reaches minus six, so it is its own remainder
      if (state_sum < 0) begin
         state_rem = state_sum;
      end else if (state_sum >= 2 * STATES_PER_REV) begin
         state_rem = state_sum - 6'(2 * STATES_PER_REV);
      end else if (state_sum >= STATES_PER_REV) begin
         state_rem = state_sum - STATES_PER_REV;
      end else begin
         state_rem = state_sum;
      end
   end

   // Duty is the drive magnitude limited to the full pulse width
   always_comb begin
      magnitude = drive_negative ? ((POS_W+1)'(0) - {1'b1, control_value})
                                 : {1'b0, control_value};
      duty_limited = (magnitude > (POS_W+1)'(DUTY_MAX)) ? DUTY_MAX : magnitude[DUTY_W-1:0];
   end

   // Position step; a jump of five states is one step the other way round
   always_comb begin
      state_diff = $signed({1'b0, rotor_state}) - $signed({1'b0, last_rotor_state});
      if (state_diff == 4'sd5) begin
         pos_step = -4'sd1;
      end else if (state_diff == -4'sd5) begin
         pos_step = 4'sd1;
      end else begin
         pos_step = state_diff;
      end
      result.position      = rotor_position + {{(POS_W-4){pos_step[3]}}, pos_step};
      result.rotor_state   = rotor_state;
      result.phase_enables = phase_lookup(state_rem[2:0]);
      result.duty          = duty_limited;
   end

endmodule

// File: design/bcpc_pd_control.sv
// Control tick datapath: speed estimate, PD term, speed-limit term and the
// saturated drive value. Uses bcpc_pkg.

module bcpc_pd_control
   import bcpc_pkg::*;
(
   input  cfg_type          cfg,
   input  logic [POS_W-1:0] rotor_position,
   input  logic [POS_W-1:0] position_at_tick,
   output tick_result_type  result
);

   logic signed [POS_W-1:0] delta;
   logic signed [POS_W:0]   err;
   logic signed [35:0]      delta_x10;
   logic signed [35:0]      derr;
   logic [POS_W-1:0]        vel;
   logic [POS_W:0]          abs_vel;
   logic [16:0]             limit;
   logic signed [33:0]      headroom;
   logic signed [8:0]       kp;
   logic signed [8:0]       kd;
   logic signed [41:0]      p_term;
   logic signed [44:0]      d_term;
   logic signed [42:0]      s_term;
   logic signed [ACC_W-1:0] yr;
   logic signed [ACC_W-1:0] ys;
   logic signed [ACC_W-1:0] y;

   // Position change over the tick period, in states per second
   always_comb begin
      delta     = $signed(rotor_position - position_at_tick);
      delta_x10 = 36'(delta) * TICKS_PER_SEC;
      derr      = -delta_x10;
      if ((delta_x10[35:31] == 5'b00000) || (delta_x10[35:31] == 5'b11111)) begin
         vel = delta_x10[31:0];
      end else begin
         vel = delta_x10[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      abs_vel = vel[31] ? ((POS_W+1)'(0) - {1'b1, vel}) : {1'b0, vel};
   end

   // Exact error and the two candidate drive terms
   always_comb begin
      err      = $signed({cfg.target_position[POS_W-1], cfg.target_position})
                 - $signed({rotor_position[POS_W-1], rotor_position});
      limit    = (cfg.max_speed == 16'd0) ? 17'(DUTY_MAX) : {1'b0, cfg.max_speed};
      headroom = $signed({17'b0, limit}) - $signed({1'b0, abs_vel});
      kp       = $signed({1'b0, cfg.prop_gain});
      kd       = $signed({1'b0, cfg.deriv_gain});
      p_term   = kp * err;
      d_term   = kd * derr;
      s_term   = kp * headroom;
      yr       = ACC_W'(p_term) + ACC_W'(d_term);
      ys       = err[POS_W] ? -ACC_W'(s_term) : ACC_W'(s_term);
   end

   // Moving backwards takes the larger term, otherwise the smaller; then saturate
   always_comb begin
      if (vel[31]) begin
         y = (ys > yr) ? ys : yr;
      end else begin
         y = (ys > yr) ? yr : ys;
      end
      if ((y[ACC_W-1:31] == '0) || (y[ACC_W-1:31] == '1)) begin
         result.drive_value = y[31:0];
      end else begin
         result.drive_value = y[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      result.speed = vel;
   end

endmodule

// File: design/bldc_commutation_position_control_unit.sv
// Top level of the BLDC commutation and position control unit: input and
// result registers, state and configuration registers. Uses bcpc_pkg,
// bcpc_commutation and bcpc_pd_control.

// The unit takes one word per clock cycle unless a stalled result keeps the
// input register full, and returns a registered result word for each. A word
// with tuser low is a hall sensor edge (sensor bits in tdata[2:0]); a word
// with tuser high is a 100 ms control tick. Every result carries the current
// phase pattern, duty, rotor position, drive value and speed. The input
// register is free again as soon as its word moves to the result register,
// so a word can be taken while a result waits. The tick datapath, three
// narrow gain multiplies feeding one compare and a saturation, sets the
// cycle time. Configuration writes must only happen while no word is in
// flight.

module bldc_commutation_position_control_unit
   import bcpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] hall_state, [7:3] zero
   input  logic                  req_tuser,   // [0] operation
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] phase_enables, [15:6] duty,
                                              // [47:16] position, [79:48] drive_value,
                                              // [111:80] speed
   // Configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Input register
   logic              in_valid_ff, in_valid_in;
   op_type            in_op_ff;
   logic [HALL_W-1:0] in_hall_ff;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   // Block state
   logic [POS_W-1:0]   rotor_position_ff, rotor_position_in;
   logic [HALL_W-1:0]  last_rotor_state_ff, last_rotor_state_in;
   logic [POS_W-1:0]   position_at_tick_ff, position_at_tick_in;
   logic [POS_W-1:0]   control_value_ff, control_value_in;
   logic [POS_W-1:0]   last_speed_ff, last_speed_in;
   logic [DUTY_W-1:0]  last_duty_ff, last_duty_in;
   logic [PHASE_W-1:0] last_phases_ff, last_phases_in;

   // Configuration
   cfg_type cfg_ff, cfg_in;

   logic            advance;
   logic            req_accept;
   hall_result_type hall_res;
   tick_result_type tick_res;

   // Datapath units
   bcpc_commutation u_commutation (
      .hall_state       (in_hall_ff),
      .rotor_origin     (cfg_ff.rotor_origin),
      .control_value    (control_value_ff),
      .last_rotor_state (last_rotor_state_ff),
      .rotor_position   (rotor_position_ff),
      .result           (hall_res)
   );

   bcpc_pd_control u_pd_control (
      .cfg              (cfg_ff),
      .rotor_position   (rotor_position_ff),
      .position_at_tick (position_at_tick_ff),
      .result           (tick_res)
   );

   // Handshake: a word moves on when the result register is empty or being read
   always_comb begin
      advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_accept   = req_tvalid && req_tready;
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   // Next state and result word
   always_comb begin
      rotor_position_in   = rotor_position_ff;
      last_rotor_state_in = last_rotor_state_ff;
      position_at_tick_in = position_at_tick_ff;
      control_value_in    = control_value_ff;
      last_speed_in       = last_speed_ff;
      last_duty_in        = last_duty_ff;
      last_phases_in      = last_phases_ff;
      if (advance) begin
         if (in_op_ff == OP_HALL_EDGE) begin
            rotor_position_in   = hall_res.position;
            last_rotor_state_in = hall_res.rotor_state;
            last_duty_in        = hall_res.duty;
            last_phases_in      = hall_res.phase_enables;
         end else begin
            control_value_in    = tick_res.drive_value;
            last_speed_in       = tick_res.speed;
            position_at_tick_in = rotor_position_ff;
         end
      end
      rsp_data_in.phase_enables = last_phases_in;
      rsp_data_in.duty          = last_duty_in;
      rsp_data_in.position      = rotor_position_in;
      rsp_data_in.drive_value   = control_value_in;
      rsp_data_in.speed         = last_speed_in;
   end

   // Configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROTOR_ORIGIN:    cfg_in.rotor_origin    = csr_wdata[2:0];
            CSR_PROP_GAIN:       cfg_in.prop_gain       = csr_wdata[7:0];
            CSR_DERIV_GAIN:      cfg_in.deriv_gain      = csr_wdata[7:0];
            CSR_MAX_SPEED:       cfg_in.max_speed       = csr_wdata[15:0];
            CSR_TARGET_POSITION: cfg_in.target_position = csr_wdata[POS_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         rotor_position_ff   <= '0;
         last_rotor_state_ff <= '0;
         position_at_tick_ff <= '0;
         control_value_ff    <= '0;
         last_speed_ff       <= '0;
         last_duty_ff        <= '0;
         last_phases_ff      <= '0;
         cfg_ff.rotor_origin    <= '0;
         cfg_ff.prop_gain       <= PROP_GAIN_RESET;
         cfg_ff.deriv_gain      <= DERIV_GAIN_RESET;
         cfg_ff.max_speed       <= '0;
         cfg_ff.target_position <= '0;
      end else begin
         in_valid_ff         <= in_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         rotor_position_ff   <= rotor_position_in;
         last_rotor_state_ff <= last_rotor_state_in;
         position_at_tick_ff <= position_at_tick_in;
         control_value_ff    <= control_value_in;
         last_speed_ff       <= last_speed_in;
         last_duty_ff        <= last_duty_in;
         last_phases_ff      <= last_phases_in;
         cfg_ff              <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= op_type'(req_tuser);
         in_hall_ff <= req_tdata[HALL_W-1:0];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Duty never exceeds the full pulse width
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.duty <= DUTY_MAX))
      else $error("duty above full pulse width");

   // A stalled word leaves the block state untouched
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready)
      |=> ($stable(rotor_position_ff) && $stable(control_value_ff)))
      else $error("state changed while the result side stalled");

   // The result word reports the state left by its own input word
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((rsp_data_ff.position == rotor_position_ff)
                   && (rsp_data_ff.drive_value == control_value_ff)))
      else $error("result word out of step with block state");

endmodule

// File: dv/bcpc_telemetry_checker.sv
`timescale 1ns / 100ps
// Watching checker for the BLDC commutation and position control unit: it
// tracks configuration writes, predicts every result word and compares it.
// Depends on bcpc_pkg for the port widths, the register indexes and the word layout.

module bcpc_telemetry_checker
   import bcpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    words_pending
);

   // Drive state to switch pattern, state zero in the lowest six bits.
   localparam logic [47:0] SWITCH_PATTERNS =
      {6'h00, 6'h00, 6'h06, 6'h24, 6'h21, 6'h09, 6'h18, 6'h12};
   // Sensor code to rotor state, code zero in the lowest three bits.
   localparam logic [23:0] ROTOR_OF_SENSOR =
      {3'd7, 3'd2, 3'd0, 3'd1, 3'd4, 3'd3, 3'd5, 3'd7};
   localparam longint SPEED_FLOOR = 1000;
   localparam longint TICK_RATE   = 10;

   // Copy of the configuration and of the motor state.
   cfg_type           settings;
   logic [POS_W-1:0]  rotor_pos;
   logic [POS_W-1:0]  pos_at_tick;
   logic [POS_W-1:0]  drive_word;
   logic [POS_W-1:0]  speed_word;
   logic [HALL_W-1:0] prev_rotor;
   logic [DUTY_W-1:0] held_duty;
   logic [PHASE_W-1:0] held_pattern;

   rsp_word_type telemetry_due[$];
   rsp_word_type seen;
   rsp_word_type want;
   int           fail_count    = 0;
   int           pending_count = 0;

   assign mismatches    = fail_count;
   assign words_pending = pending_count;

   function automatic longint clamp_to_word(input longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      if (v < -64'sd2147483648)
         return -64'sd2147483648;
      return v;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] wanted);
      $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, wanted);
      fail_count++;
   endtask

   // Applies one input word to the motor state and forms the result word.
   task automatic advance_motor_model(input op_type op, input logic [HALL_W-1:0] hall,
                                      output rsp_word_type w);
      longint ctrl, mag, pos, delta, err, derr, vel, lim, absvel, yr, ys, y, pg, dg;
      int     rs, origin, sum, rem, step, prev;
      logic [2:0] slot;
      if (op == OP_HALL_EDGE) begin
         // Commutation: drive state leads the rotor by two states in the
         // direction of the drive, with a truncating remainder.
         ctrl   = longint'($signed(drive_word));
         rs     = int'(ROTOR_OF_SENSOR[hall*3 +: 3]);
         origin = int'(settings.rotor_origin);
         prev   = int'(prev_rotor);
         sum    = rs - origin + ((ctrl < 0) ? -2 : 2) + 6;
         rem    = sum % 6;
         slot   = rem[2:0];
         held_pattern = SWITCH_PATTERNS[slot*6 +: 6];
         mag = (ctrl < 0) ? -ctrl : ctrl;
         if (mag > SPEED_FLOOR)
            mag = SPEED_FLOOR;
         held_duty = mag[DUTY_W-1:0];
         // Position update: a jump of five states is one step the other way.
         step = rs - prev;
         if (step == 5)
            rotor_pos = rotor_pos - 1;
         else if (step == -5)
            rotor_pos = rotor_pos + 1;
         else
            rotor_pos = rotor_pos + step;
         prev_rotor = rs[HALL_W-1:0];
      end else begin
         // Control tick: PD term against speed-limit term, exact until the
         // final saturation.
         pos    = longint'($signed(rotor_pos));
         delta  = longint'($signed(rotor_pos - pos_at_tick));
         err    = longint'($signed(settings.target_position));
         err    = err - pos;
         derr   = -delta * TICK_RATE;
         vel    = clamp_to_word(delta * TICK_RATE);
         lim    = longint'(settings.max_speed);
         if (lim == 0)
            lim = SPEED_FLOOR;
         absvel = (vel < 0) ? -vel : vel;
         pg     = longint'(settings.prop_gain);
         dg     = longint'(settings.deriv_gain);
         yr     = pg * err + dg * derr;
         ys     = pg * (lim - absvel);
         if (err < 0)
            ys = -ys;
         if (vel < 0)
            y = (ys > yr) ? ys : yr;
         else
            y = (ys > yr) ? yr : ys;
         drive_word  = 32'(clamp_to_word(y));
         speed_word  = 32'(vel);
         pos_at_tick = rotor_pos;
      end
      w.phase_enables = held_pattern;
      w.duty          = held_duty;
      w.position      = rotor_pos;
      w.drive_value   = drive_word;
      w.speed         = speed_word;
   endtask

   // Results are compared before new words are predicted, so a result leaving
   // at the same edge as a word arrives is matched against older words.
   always @(posedge clock) begin
      if (reset) begin
         settings.rotor_origin    = '0;
         settings.prop_gain       = PROP_GAIN_RESET;
         settings.deriv_gain      = DERIV_GAIN_RESET;
         settings.max_speed       = '0;
         settings.target_position = '0;
         rotor_pos    = '0;
         pos_at_tick  = '0;
         drive_word   = '0;
         speed_word   = '0;
         prev_rotor   = '0;
         held_duty    = '0;
         held_pattern = '0;
         telemetry_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (telemetry_due.size() == 0) begin
               flag_mismatch("word with nothing outstanding, position", seen.position, '0);
            end else begin
               want = telemetry_due.pop_front();
               if (seen.phase_enables !== want.phase_enables)
                  flag_mismatch("phase_enables", 32'(seen.phase_enables),
                                32'(want.phase_enables));
               if (seen.duty !== want.duty)
                  flag_mismatch("duty", 32'(seen.duty), 32'(want.duty));
               if (seen.position !== want.position)
                  flag_mismatch("position", seen.position, want.position);
               if (seen.drive_value !== want.drive_value)
                  flag_mismatch("drive_value", seen.drive_value, want.drive_value);
               if (seen.speed !== want.speed)
                  flag_mismatch("speed", seen.speed, want.speed);
            end
         end
         // Register writes; unmapped indexes leave everything alone.
         if (csr_we) begin
            case (csr_index)
               CSR_ROTOR_ORIGIN:    settings.rotor_origin    = csr_wdata[2:0];
               CSR_PROP_GAIN:       settings.prop_gain       = csr_wdata[7:0];
               CSR_DERIV_GAIN:      settings.deriv_gain      = csr_wdata[7:0];
               CSR_MAX_SPEED:       settings.max_speed       = csr_wdata[15:0];
               CSR_TARGET_POSITION: settings.target_position = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_motor_model(op_type'(req_tuser), req_tdata[HALL_W-1:0], want);
            telemetry_due.push_back(want);
         end
      end
      pending_count <= telemetry_due.size();
   end

endmodule

// File: dv/bldc_commutation_position_control_unit_tb.sv
`timescale 1ns / 100ps
// Top of the testbench for the BLDC commutation and position control unit:
// clock, reset, stimulus and verdict. Depends on bcpc_pkg, the unit itself
// and bcpc_telemetry_checker, which predicts and compares the result words.

module bldc_commutation_position_control_unit_tb;
   import bcpc_pkg::*;

   // Hall codes in rotor order, rotor state zero in the lowest three bits.
   localparam logic [17:0] ROTATION_CODES = {3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
   localparam int CSR_UNMAPPED_LO = 5;
   localparam int CSR_UNMAPPED_HI = 7;
   localparam int STATES          = 6;
   localparam int PHASES          = 10;
   localparam int WORDS_PER_PHASE = 125;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   int                    mismatches;
   int                    words_pending;

   // Odds of a gap before a word and of a stall at the result side, as one
   // in N; zero turns them off.
   int gap_odds   = 0;
   int stall_odds = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bldc_commutation_position_control_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bcpc_telemetry_checker telemetry_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   // Presents one word, possibly after a gap, and waits until it is taken.
   task automatic send_word(input op_type op, input logic [HALL_W-1:0] hall);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-HALL_W){1'b0}}, hall};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the sender back until every outstanding result has been taken.
   task automatic drain_results;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   // Writes all five registers, then some junk to an unmapped index.
   task automatic load_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROTOR_ORIGIN;
      csr_wdata <= {29'd0, c.rotor_origin};
      @(posedge clock);
      csr_index <= CSR_PROP_GAIN;
      csr_wdata <= {24'd0, c.prop_gain};
      @(posedge clock);
      csr_index <= CSR_DERIV_GAIN;
      csr_wdata <= {24'd0, c.deriv_gain};
      @(posedge clock);
      csr_index <= CSR_MAX_SPEED;
      csr_wdata <= {16'd0, c.max_speed};
      @(posedge clock);
      csr_index <= CSR_TARGET_POSITION;
      csr_wdata <= c.target_position;
      @(posedge clock);
      csr_index <= 3'($urandom_range(CSR_UNMAPPED_LO, CSR_UNMAPPED_HI));
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: ready with random stall bursts while stalls are enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      cfg_type c;
      int      spot;
      int      dir;
      int      pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a tick before any edge, every sensor code including
      // the two impossible ones, a repeated code and both wrap directions.
      send_word(OP_CTRL_TICK, 3'd0);
      for (int h = 0; h < 8; h++)
         send_word(OP_HALL_EDGE, 3'(h));
      send_word(OP_HALL_EDGE, 3'd1);
      send_word(OP_HALL_EDGE, 3'd5);
      send_word(OP_HALL_EDGE, 3'd5);
      send_word(OP_HALL_EDGE, 3'd1);
      send_word(OP_CTRL_TICK, 3'd7);

      // Most negative drive: negative lead and negative remainders, some of which
      // give the drive states that switch everything off.
      drain_results();
      c.rotor_origin    = 3'd7;
      c.prop_gain       = 8'hFF;
      c.deriv_gain      = 8'hFF;
      c.max_speed       = 16'hFFFF;
      c.target_position = 32'h8000_0000;
      load_settings(c);
      send_word(OP_CTRL_TICK, 3'd0);
      send_word(OP_HALL_EDGE, 3'd5);
      send_word(OP_HALL_EDGE, 3'd4);
      send_word(OP_HALL_EDGE, 3'd6);
      send_word(OP_HALL_EDGE, 3'd2);
      send_word(OP_CTRL_TICK, 3'd0);

      // Zero gains give zero drive; then a large positive error with speed limit one.
      drain_results();
      c.rotor_origin    = 3'd0;
      c.prop_gain       = 8'h00;
      c.deriv_gain      = 8'h00;
      c.max_speed       = 16'h0000;
      c.target_position = 32'h7FFF_FFFF;
      load_settings(c);
      send_word(OP_CTRL_TICK, 3'd0);
      send_word(OP_HALL_EDGE, 3'd3);
      send_word(OP_CTRL_TICK, 3'd0);
      drain_results();
      c.rotor_origin = 3'd3;
      c.prop_gain    = 8'hFF;
      c.max_speed    = 16'h0001;
      load_settings(c);
      send_word(OP_CTRL_TICK, 3'd0);
      send_word(OP_HALL_EDGE, 3'd2);

      // Random phases: mostly clean rotation with random direction changes,
      // repeats and ticks, some arbitrary sensor codes; fresh settings each
      // phase, with the sender held back until the results are in.
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         c.rotor_origin = 3'($urandom_range(0, 7));
         c.prop_gain    = 8'(($urandom_range(0, 3) == 0) ?
                          ($urandom_range(0, 1) ? 8'hFF : 8'h00) : $urandom_range(1, 60));
         c.deriv_gain   = 8'(($urandom_range(0, 3) == 0) ?
                          ($urandom_range(0, 1) ? 8'hFF : 8'h00) : $urandom_range(1, 60));
         case ($urandom_range(0, 3))
            0:       c.max_speed = 16'h0000;
            1:       c.max_speed = 16'hFFFF;
            default: c.max_speed = 16'($urandom_range(1, 300));
         endcase
         case ($urandom_range(0, 9))
            0:       c.target_position = 32'h8000_0000;
            1:       c.target_position = 32'h7FFF_FFFF;
            default: c.target_position = $urandom_range(0, 400) - 200;
         endcase
         load_settings(c);

         // No idling in the last phase; otherwise none, light or heavy.
         if (p == PHASES - 1) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       gap_odds = 0;
               1:       gap_odds = 3;
               default: gap_odds = 12;
            endcase
            case ($urandom_range(0, 2))
               0:       stall_odds = 0;
               1:       stall_odds = 3;
               default: stall_odds = 12;
            endcase
         end

         spot = $urandom_range(0, STATES - 1);
         dir  = $urandom_range(0, 1) ? 1 : -1;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
               send_word(OP_CTRL_TICK, 3'($urandom_range(0, 7)));
            end else if (pick < 28) begin
               send_word(OP_HALL_EDGE, 3'($urandom_range(0, 7)));
            end else begin
               if (pick < 33)
                  dir = -dir;
               else if (pick >= 36)
                  spot = (spot + dir + STATES) % STATES;
               send_word(OP_HALL_EDGE, ROTATION_CODES[spot*3 +: 3]);
            end
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && words_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
design/bcpc_pkg.sv
design/bcpc_commutation.sv
design/bcpc_pd_control.sv
design/bldc_commutation_position_control_unit.sv
dv/bcpc_telemetry_checker.sv
dv/bldc_commutation_position_control_unit_tb.sv
